[src/cartridge_bank_controller_top_defines.svh]
// assertion macros for the cartridge bank controller checker
`ifndef CARTRIDGE_BANK_CONTROLLER_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_TOP_DEFINES_SVH

// checked outside reset
`define CBC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CBC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/cbc_pkg.sv]
// types and constants shared by the cartridge bank controller modules
package cbc_pkg;

  localparam int unsigned CBC_BANK_BYTES  = 8192;
  localparam int unsigned CBC_OFFSET_W    = $clog2(CBC_BANK_BYTES);
  // power of two, pointers wrap naturally
  localparam int unsigned CBC_QUEUE_DEPTH = 2;

  // battery backed cartridge types
  localparam logic [7:0] CT_MBC1_RAM_BAT    = 8'h03;
  localparam logic [7:0] CT_MBC2_BAT        = 8'h06;
  localparam logic [7:0] CT_ROM_RAM_BAT     = 8'h09;
  localparam logic [7:0] CT_MBC3_TIMER_BAT  = 8'h0F;
  localparam logic [7:0] CT_MBC3_TRAM_BAT   = 8'h10;
  localparam logic [7:0] CT_MBC3_RAM_BAT    = 8'h13;
  localparam logic [7:0] CT_MBC5_RAM_BAT    = 8'h1B;

  localparam logic [7:0] RAM_ENABLE_BITS    = 8'h0A;

  typedef enum logic [2:0] {
    REG_ROM_FIXED  = 3'd0,
    REG_ROM_BANKED = 3'd1,
    REG_CTRL       = 3'd2,
    REG_CART_RAM   = 3'd3,
    REG_OTHER      = 3'd4
  } region_e;

  // one classified request handed from front to back
  typedef struct packed {
    region_e                  region;
    logic [20:0]              rom_address;
    logic                     save_request;
    logic [6:0]               rom_bank;
    logic [1:0]               ram_bank;
    logic                     mode;
    logic                     ram_wr;
    logic                     ram_rd;
    logic [1:0]               ram_bank_sel;
    logic [CBC_OFFSET_W-1:0]  ram_offset;
    logic [7:0]               wr_data;
  } entry_t;

endpackage

[src/cbc_front.sv]
// front end: request decode, bank registers and cartridge type register
module cbc_front #(
  parameter int unsigned RAM_BANKS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             accept_i,
  input  logic             action_i,
  input  logic [15:0]      address_i,
  input  logic [7:0]       data_in_i,
  output cbc_pkg::entry_t  entry_o
);
  import cbc_pkg::*;

  localparam logic [2:0] NBANKS = 3'(RAM_BANKS);

  logic [7:0] cart_type_q;
  logic [6:0] rom_bank_q, rom_bank_d;
  logic [1:0] ram_bank_q, ram_bank_d;
  logic       mode_q, mode_d;
  logic       battery;
  logic [2:0] bank_mod;

  always_comb begin
    case (cart_type_q) inside
      CT_MBC1_RAM_BAT, CT_MBC2_BAT, CT_ROM_RAM_BAT, CT_MBC3_TIMER_BAT,
      CT_MBC3_TRAM_BAT, CT_MBC3_RAM_BAT, CT_MBC5_RAM_BAT: battery = 1'b1;
      default: battery = 1'b0;
    endcase
  end

  // ram bank modulo bank count, at most three subtractions on two bits
  always_comb begin
    bank_mod = {1'b0, ram_bank_q};
    for (int k = 0; k < 3; k++) begin
      if (bank_mod >= NBANKS) begin
        bank_mod = bank_mod - NBANKS;
      end
    end
  end

  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    mode_d     = mode_q;
    entry_o    = '0;
    entry_o.region = REG_OTHER;
    case (address_i[15:13]) inside
      [3'b000:3'b011]: begin
        if (action_i) begin
          entry_o.region = REG_CTRL;
          case (address_i[14:13])
            2'b00: begin
              entry_o.save_request =
                ((data_in_i & RAM_ENABLE_BITS) != RAM_ENABLE_BITS) && battery;
            end
            2'b01: begin
              rom_bank_d[4:0] = (data_in_i[4:0] == 5'd0) ? 5'd1 : data_in_i[4:0];
            end
            2'b10: begin
              if (!mode_q) begin
                rom_bank_d[6:5] = data_in_i[1:0];
              end else begin
                ram_bank_d = data_in_i[1:0];
              end
            end
            default: begin
              mode_d = data_in_i[0];
            end
          endcase
        end else if (!address_i[14]) begin
          entry_o.region      = REG_ROM_FIXED;
          entry_o.rom_address = {5'd0, address_i};
        end else begin
          entry_o.region      = REG_ROM_BANKED;
          entry_o.rom_address = {rom_bank_q, address_i[13:0]};
        end
      end
      3'b101: begin
        entry_o.region = REG_CART_RAM;
        entry_o.ram_wr = action_i;
        entry_o.ram_rd = !action_i;
      end
      default: begin
        entry_o.region = REG_OTHER;
      end
    endcase
    entry_o.ram_bank_sel = bank_mod[1:0];
    entry_o.ram_offset   = address_i[CBC_OFFSET_W-1:0];
    entry_o.wr_data      = data_in_i;
    entry_o.rom_bank     = rom_bank_d;
    entry_o.ram_bank     = ram_bank_d;
    entry_o.mode         = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_type_q <= 8'd0;
      rom_bank_q  <= 7'd1;
      ram_bank_q  <= 2'd0;
      mode_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cart_type_q <= cfg_data_i;
      end
      if (accept_i) begin
        rom_bank_q <= rom_bank_d;
        ram_bank_q <= ram_bank_d;
        mode_q     <= mode_d;
      end
    end
  end

endmodule

[src/cbc_queue.sv]
// short request queue between front end and back end
module cbc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cbc_pkg::entry_t  push_entry_i,
  input  logic             pop_i,
  output cbc_pkg::entry_t  pop_entry_o,
  output logic             not_empty_o,
  output logic             full_o
);
  import cbc_pkg::*;

  localparam int unsigned PTR_W = $clog2(CBC_QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(CBC_QUEUE_DEPTH + 1);

  entry_t             store_q [CBC_QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, count_d;

  assign pop_entry_o = store_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign full_o      = (count_q == CNT_W'(CBC_QUEUE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

[src/cbc_back.sv]
// back end: cart ram access and output register
module cbc_back #(
  parameter int unsigned RAM_BANKS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  cbc_pkg::entry_t  entry_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output cbc_pkg::entry_t  out_entry_o,
  output logic [7:0]       read_data_o
);
  import cbc_pkg::*;

  localparam int unsigned DEPTH = RAM_BANKS * CBC_BANK_BYTES;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [IDX_W-1:0] idx;
  logic [7:0]       rd_q;
  logic             valid_q;
  entry_t           out_q;

  assign idx   = IDX_W'({entry_i.ram_bank_sel, entry_i.ram_offset});
  assign pop_o = avail_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.ram_wr) begin
      mem[idx] <= entry_i.wr_data;
    end
    if (pop_o && entry_i.ram_rd) begin
      rd_q <= mem[idx];
    end
    if (pop_o) begin
      out_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_entry_o = out_q;
  assign read_data_o = out_q.ram_rd ? rd_q : 8'd0;

endmodule

[src/cartridge_bank_controller_top.sv]
// top level of the cartridge bank controller
// MBC1-style bank controller on a CPU bus. Each request (read or write, 16-bit
// address, one byte) is decoded by the front end, which also owns the rom bank,
// ram bank and mode registers and the cartridge type register, so bank writes
// take effect for the very next request. Classified requests wait in a
// two-entry queue; the back end performs the cart ram read or write on its
// single-port ram and registers the result. One request per clock is
// sustained while out_stall_i is low; a result passes through the queue and
// then the back end output register with its registered ram read. in_stall_o
// rises only when the queue is full, so the front keeps accepting while a
// finished result waits on out_stall_i. The cart_type register is written
// through the cfg port (always ready) and should only change while idle.
// Cart ram is not cleared at reset: reading a byte never written gives
// undefined data.
module cartridge_bank_controller_top #(
  parameter int unsigned RAM_BANKS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // bus request
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_in_i,
  // result
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  region_o,
  output logic [20:0] rom_address_o,
  output logic [7:0]  read_data_o,
  output logic        save_request_o,
  output logic [6:0]  rom_bank_now_o,
  output logic [1:0]  ram_bank_now_o,
  output logic        mode_now_o
);
  import cbc_pkg::*;

  entry_t front_entry;
  entry_t queue_entry;
  entry_t out_entry;
  logic   accept;
  logic   q_full;
  logic   q_not_empty;
  logic   pop;

  // config register never blocks
  assign cfg_ready_o = 1'b1;

  // stall only on queue full, independent of in_valid_i
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  cbc_front #(
    .RAM_BANKS (RAM_BANKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .action_i   (action_i),
    .address_i  (address_i),
    .data_in_i  (data_in_i),
    .entry_o    (front_entry)
  );

  cbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_entry_i (front_entry),
    .pop_i        (pop),
    .pop_entry_o  (queue_entry),
    .not_empty_o  (q_not_empty),
    .full_o       (q_full)
  );

  cbc_back #(
    .RAM_BANKS (RAM_BANKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_not_empty),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_entry_o (out_entry),
    .read_data_o (read_data_o)
  );

  // result fields straight from the back end output register
  assign region_o       = out_entry.region;
  assign rom_address_o  = out_entry.rom_address;
  assign save_request_o = out_entry.save_request;
  assign rom_bank_now_o = out_entry.rom_bank;
  assign ram_bank_now_o = out_entry.ram_bank;
  assign mode_now_o     = out_entry.mode;

endmodule

[src/cbc_checker.sv]
// port level checks for the cartridge bank controller
`include "cartridge_bank_controller_top_defines.svh"

module cbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  region_o,
  input logic [20:0] rom_address_o,
  input logic [7:0]  read_data_o,
  input logic        save_request_o,
  input logic [6:0]  rom_bank_now_o
);
  import cbc_pkg::*;

  `CBC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(region_o) && $stable(rom_address_o) && $stable(read_data_o), "stalled result changed")
  `CBC_ASSERT(a_rom_bank_low, out_valid_o |-> rom_bank_now_o[4:0] != 5'd0, "rom bank low bits zero")
  `CBC_ASSERT(a_rom_addr_zero, out_valid_o && region_o != REG_ROM_FIXED && region_o != REG_ROM_BANKED |-> rom_address_o == 21'd0, "rom address outside rom region")
  `CBC_ASSERT(a_save_ctrl, out_valid_o && save_request_o |-> region_o == REG_CTRL, "save request outside control write")
  `CBC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind cartridge_bank_controller_top cbc_checker u_cbc_checker (.*);
